[rtl/cdad_pkg.sv]
// ----------------------------------------------------------------------------
// cdad_pkg
// Shared types, constants and calendar helpers for the date adder.
// ----------------------------------------------------------------------------
package cdad_pkg;

  localparam int INCREMENT_WIDTH = 16;
  localparam int REM_WIDTH       = INCREMENT_WIDTH + 1;

  localparam int YEAR_WIDTH  = 14;
  localparam int MONTH_WIDTH = 4;
  localparam int DAY_WIDTH   = 5;
  localparam int MOD_WIDTH   = 9;   // holds year mod 400
  localparam int CFG_IDX_WIDTH = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_START_YEAR  = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_START_MONTH = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_START_DAY   = 2'd2;

  localparam logic [YEAR_WIDTH-1:0]  START_YEAR_RST  = 14'd2000;
  localparam logic [MONTH_WIDTH-1:0] START_MONTH_RST = 4'd1;
  localparam logic [DAY_WIDTH-1:0]   START_DAY_RST   = 5'd1;
  localparam logic [MOD_WIDTH-1:0]   START_MOD_RST   = 9'd0;  // 2000 mod 400

  localparam logic [YEAR_WIDTH-1:0]  YEAR_MAX     = 14'd9999;
  localparam logic [MONTH_WIDTH-1:0] MONTH_JAN    = 4'd1;
  localparam logic [MONTH_WIDTH-1:0] MONTH_FEB    = 4'd2;
  localparam logic [MONTH_WIDTH-1:0] MONTH_DEC    = 4'd12;
  localparam logic [DAY_WIDTH-1:0]   DAY_LAST_DEC = 5'd31;
  localparam logic [DAY_WIDTH-1:0]   DAY_FEB_LEAP = 5'd29;

  localparam int                   LEAP_CYCLE = 400;
  localparam logic [MOD_WIDTH-1:0] MOD_LAST   = 9'(LEAP_CYCLE - 1);
  localparam logic [MOD_WIDTH-1:0] CENT_1     = 9'd100;
  localparam logic [MOD_WIDTH-1:0] CENT_2     = 9'd200;
  localparam logic [MOD_WIDTH-1:0] CENT_3     = 9'd300;

  typedef struct packed {
    logic [INCREMENT_WIDTH-1:0] day_increment;
    logic                       reload_start;
  } item_t;

  typedef struct packed {
    logic [YEAR_WIDTH-1:0]  out_year;
    logic [MONTH_WIDTH-1:0] out_month;
    logic [DAY_WIDTH-1:0]   out_day;
    logic                   overflow;
  } result_t;

  // Month length in a common year; months outside 1..12 count as 31 days.
  function automatic logic [DAY_WIDTH-1:0] month_len(input logic [MONTH_WIDTH-1:0] m);
    logic [DAY_WIDTH-1:0] len;
    case (m)
      4'd1:    len = 5'd31;
      4'd2:    len = 5'd28;
      4'd3:    len = 5'd31;
      4'd4:    len = 5'd30;
      4'd5:    len = 5'd31;
      4'd6:    len = 5'd30;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd31;
      4'd9:    len = 5'd30;
      4'd10:   len = 5'd31;
      4'd11:   len = 5'd30;
      4'd12:   len = 5'd31;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // Year mod 400 by six conditional subtracts of 400 times a power of two.
  function automatic logic [MOD_WIDTH-1:0] year_mod(input logic [YEAR_WIDTH-1:0] y);
    logic [YEAR_WIDTH-1:0] r;
    logic [YEAR_WIDTH-1:0] d;
    r = y;
    for (int k = 5; k >= 0; k--) begin
      d = YEAR_WIDTH'(LEAP_CYCLE << k);
      if (r >= d) begin
        r = r - d;
      end
    end
    return r[MOD_WIDTH-1:0];
  endfunction

  // Leap test from year mod 400.
  function automatic logic is_leap(input logic [MOD_WIDTH-1:0] r);
    logic century;
    century = (r == '0) || (r == CENT_1) || (r == CENT_2) || (r == CENT_3);
    return ((r[1:0] == 2'b00) && !century) || (r == '0);
  endfunction

endpackage

[rtl/calendar_date_add_days_unit.sv]
// ----------------------------------------------------------------------------
// calendar_date_add_days_unit
// Gregorian date adder: advances a stored date by a day increment.
// ----------------------------------------------------------------------------
// The block keeps a current date (year, month, day). Each input item carries
// a day increment and a reload flag; with the flag set the date is first
// reloaded from the start_year/start_month/start_day registers. The block
// then walks forward one month per clock cycle, subtracting the length of
// each month crossed (February has 29 days in leap years, Gregorian rules),
// and returns one result item with the new date. An item is first accepted,
// then the months are walked, then a final step writes the result once
// the output register is free; a full 16-bit increment crosses up to
// about 2200 months. The block takes no new item while it walks. Moving
// past December 9999 saturates the date at 9999-12-31, drops the remaining
// days and sets overflow. Write the start registers only while idle.
// ----------------------------------------------------------------------------
module calendar_date_add_days_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cdad_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [cdad_pkg::YEAR_WIDTH-1:0]    cfg_data,
  input  logic                               item_valid,
  output logic                               item_ready,
  input  cdad_pkg::item_t                    item,
  output logic                               result_valid,
  input  logic                               result_ready,
  output cdad_pkg::result_t                  result
);

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t state;

  // Start registers
  logic [cdad_pkg::YEAR_WIDTH-1:0]  start_year;
  logic [cdad_pkg::MONTH_WIDTH-1:0] start_month;
  logic [cdad_pkg::DAY_WIDTH-1:0]   start_day;

  // Current date, with the year's position in the 400-year cycle
  logic [cdad_pkg::YEAR_WIDTH-1:0]  year;
  logic [cdad_pkg::MONTH_WIDTH-1:0] month;
  logic [cdad_pkg::DAY_WIDTH-1:0]   day;
  logic [cdad_pkg::MOD_WIDTH-1:0]   year_pos;
  logic [cdad_pkg::REM_WIDTH-1:0]   days_remaining;

  // Step unit signals
  logic [cdad_pkg::DAY_WIDTH-1:0]   total;
  logic                             fits;
  logic                             wrap_year;
  logic                             saturate;
  logic                             out_free;
  logic                             finish;
  logic [cdad_pkg::DAY_WIDTH-1:0]   base_day;

  assign cfg_ready  = 1'b1;
  assign item_ready = (state == ST_IDLE);
  assign out_free   = !result_valid || result_ready;

  // Length of the month being crossed
  always_comb begin
    total = cdad_pkg::month_len(month);
    if (month == cdad_pkg::MONTH_FEB && cdad_pkg::is_leap(year_pos)) begin
      total = cdad_pkg::DAY_FEB_LEAP;
    end
  end

  assign fits      = (days_remaining <= cdad_pkg::REM_WIDTH'(total));
  assign wrap_year = (month >= cdad_pkg::MONTH_DEC);
  assign saturate  = !fits && wrap_year && (year >= cdad_pkg::YEAR_MAX);
  assign finish    = (state == ST_RUN) && (fits || saturate) && out_free;
  assign base_day  = item.reload_start ? start_day : day;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      start_year     <= cdad_pkg::START_YEAR_RST;
      start_month    <= cdad_pkg::START_MONTH_RST;
      start_day      <= cdad_pkg::START_DAY_RST;
      year           <= cdad_pkg::START_YEAR_RST;
      month          <= cdad_pkg::START_MONTH_RST;
      day            <= cdad_pkg::START_DAY_RST;
      year_pos       <= cdad_pkg::START_MOD_RST;
      days_remaining <= '0;
      result_valid   <= 1'b0;
    end else begin
      // Drop the result once taken, unless a new one replaces it
      if (result_valid && result_ready && !finish) begin
        result_valid <= 1'b0;
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          cdad_pkg::CFG_START_YEAR:  start_year  <= cfg_data;
          cdad_pkg::CFG_START_MONTH: start_month <= cfg_data[cdad_pkg::MONTH_WIDTH-1:0];
          cdad_pkg::CFG_START_DAY:   start_day   <= cfg_data[cdad_pkg::DAY_WIDTH-1:0];
          default: ;
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (item_valid && item_ready) begin
            if (item.reload_start) begin
              year     <= start_year;
              month    <= start_month;
              day      <= start_day;
              year_pos <= cdad_pkg::year_mod(start_year);
            end
            days_remaining <= cdad_pkg::REM_WIDTH'(base_day)
                            + cdad_pkg::REM_WIDTH'(item.day_increment);
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (fits || saturate) begin
            // Finish: hold here until the output register is free
            if (out_free) begin
              if (saturate) begin
                year  <= cdad_pkg::YEAR_MAX;
                month <= cdad_pkg::MONTH_DEC;
                day   <= cdad_pkg::DAY_LAST_DEC;
                result.out_year  <= cdad_pkg::YEAR_MAX;
                result.out_month <= cdad_pkg::MONTH_DEC;
                result.out_day   <= cdad_pkg::DAY_LAST_DEC;
                result.overflow  <= 1'b1;
              end else begin
                day <= days_remaining[cdad_pkg::DAY_WIDTH-1:0];
                result.out_year  <= year;
                result.out_month <= month;
                result.out_day   <= days_remaining[cdad_pkg::DAY_WIDTH-1:0];
                result.overflow  <= 1'b0;
              end
              days_remaining <= '0;
              result_valid   <= 1'b1;
              state          <= ST_IDLE;
            end
          end else begin
            // Advance one month
            days_remaining <= days_remaining - cdad_pkg::REM_WIDTH'(total);
            if (wrap_year) begin
              year     <= year + 1'b1;
              month    <= cdad_pkg::MONTH_JAN;
              year_pos <= (year_pos == cdad_pkg::MOD_LAST) ? '0 : year_pos + 1'b1;
            end else if (month == '0) begin
              month <= cdad_pkg::MONTH_JAN;
            end else begin
              month <= month + 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
